FILE: rtl/mqsb_pkg.sv
package mqsb_pkg;

    localparam int SLOTS_DEF      = 64;
    localparam int QUEUES_DEF     = 8;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed field widths of the stream words
    localparam int QID_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    typedef enum logic {
        MODE_PUSH = 1'b0,
        MODE_POP  = 1'b1
    } t_mode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        t_status status;
        logic    pop_ok;
    } t_op_res;

endpackage

FILE: rtl/mqsb_ram.sv
module mqsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold the last read word until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mqsb_ctrl.sv
module mqsb_ctrl
    import mqsb_pkg::*;
#(
    parameter int SLOTS  = SLOTS_DEF,
    parameter int QUEUES = QUEUES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic                       i_mode,
    input  logic [QID_W-1:0]           i_queue_id,
    output t_op_res                    o_res,
    output logic                       o_link_we,
    output logic [$clog2(SLOTS)-1:0]   o_link_waddr,
    output logic [$clog2(SLOTS+1)-1:0] o_link_wdata,
    output logic                       o_link_re,
    output logic [$clog2(SLOTS)-1:0]   o_link_raddr,
    input  logic [$clog2(SLOTS+1)-1:0] i_link_rdata,
    output logic                       o_data_we,
    output logic [$clog2(SLOTS)-1:0]   o_data_waddr,
    output logic                       o_data_re,
    output logic [$clog2(SLOTS)-1:0]   o_data_raddr
);

    localparam int LW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(SLOTS);
    localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam logic [LW-1:0] NIL  = LW'(SLOTS);
    localparam logic [LW-1:0] LAST = LW'(SLOTS - 1);

    // Free list: recycled chain in the link memory, then the untouched slots
    // from r_fill upward, which link implicitly to the next index.
    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_free_next, n_free_next;
    logic [LW-1:0] r_fill, n_fill;
    logic [LW-1:0] r_head  [QUEUES];
    logic [LW-1:0] n_head  [QUEUES];
    logic [LW-1:0] r_tail  [QUEUES];
    logic [LW-1:0] n_tail  [QUEUES];
    logic [LW-1:0] r_hnext [QUEUES];
    logic [LW-1:0] n_hnext [QUEUES];
    logic          r_pend_free, n_pend_free;
    logic          r_pend_q, n_pend_q;
    logic [QW-1:0] r_pend_qi, n_pend_qi;

    logic [7:0]    q_ext;
    logic [QW-1:0] qi;
    logic          q_ok;
    logic [LW-1:0] fh, fn, h, t, hn;
    logic          is_push, is_pop, push_ok, pop_ok;

    assign q_ext = {{(8 - QID_W){1'b0}}, i_queue_id};
    assign qi    = q_ext[QW-1:0];
    assign q_ok  = (q_ext < 8'(QUEUES));

    // The link word read last cycle is on the RAM output now; it is forwarded and stored in its prefetch register.
    assign fh = r_free_head;
    assign fn = r_pend_free ? i_link_rdata : r_free_next;
    assign h  = r_head[qi];
    assign t  = r_tail[qi];
    assign hn = (r_pend_q && (r_pend_qi == qi)) ? i_link_rdata : r_hnext[qi];

    assign is_push = i_valid && (t_mode'(i_mode) == MODE_PUSH);
    assign is_pop  = i_valid && (t_mode'(i_mode) == MODE_POP);
    assign push_ok = is_push && q_ok && (fh != NIL);
    assign pop_ok  = is_pop && q_ok && (h != NIL);

    always_comb begin
        n_free_head  = r_free_head;
        n_free_next  = r_free_next;
        n_fill       = r_fill;
        n_head       = r_head;
        n_tail       = r_tail;
        n_hnext      = r_hnext;
        n_pend_free  = 1'b0;
        n_pend_q     = 1'b0;
        n_pend_qi    = r_pend_qi;
        o_link_we    = 1'b0;
        o_link_waddr = '0;
        o_link_wdata = '0;
        o_link_re    = 1'b0;
        o_link_raddr = '0;
        o_data_we    = 1'b0;
        o_data_waddr = '0;
        o_data_re    = 1'b0;
        o_data_raddr = '0;

        if (r_pend_free) begin
            n_free_next = i_link_rdata;
        end
        if (r_pend_q) begin
            n_hnext[r_pend_qi] = i_link_rdata;
        end

        if (push_ok) begin
            o_data_we    = 1'b1;
            o_data_waddr = fh[IW-1:0];
            if (h == NIL) begin
                n_head[qi] = fh;
            end else begin
                o_link_we    = 1'b1;
                o_link_waddr = t[IW-1:0];
                o_link_wdata = fh;
                // single item queue: its head link is the one just written
                if (h == t) begin
                    n_hnext[qi] = fh;
                end
            end
            n_tail[qi]  = fh;
            n_free_head = fn;
            if (fh == r_fill) begin
                n_fill = r_fill + LW'(1);
            end
            if (fn != NIL) begin
                if (fn >= r_fill) begin
                    n_free_next = (fn == LAST) ? NIL : fn + LW'(1);
                end else begin
                    o_link_re    = 1'b1;
                    o_link_raddr = fn[IW-1:0];
                    n_pend_free  = 1'b1;
                end
            end
        end

        if (pop_ok) begin
            o_data_re    = 1'b1;
            o_data_raddr = h[IW-1:0];
            o_link_we    = 1'b1;
            o_link_waddr = h[IW-1:0];
            o_link_wdata = fh;
            n_free_head  = h;
            n_free_next  = fh;
            if (h == t) begin
                n_head[qi] = NIL;
                n_tail[qi] = NIL;
            end else begin
                n_head[qi] = hn;
                // prefetch the link of the new head unless it is the tail
                if (hn != t) begin
                    o_link_re    = 1'b1;
                    o_link_raddr = hn[IW-1:0];
                    n_pend_q     = 1'b1;
                    n_pend_qi    = qi;
                end
            end
        end
    end

    always_comb begin
        o_res.pop_ok = pop_ok;
        if (is_push && !push_ok) begin
            o_res.status = ST_OVERFLOW;
        end else if (is_pop && !pop_ok) begin
            o_res.status = ST_UNDERFLOW;
        end else begin
            o_res.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free_head <= '0;
            r_free_next <= LW'(1);
            r_fill      <= '0;
            r_pend_free <= 1'b0;
            r_pend_q    <= 1'b0;
            r_pend_qi   <= '0;
            for (int i = 0; i < QUEUES; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
        end else begin
            r_free_head <= n_free_head;
            r_free_next <= n_free_next;
            r_fill      <= n_fill;
            r_pend_free <= n_pend_free;
            r_pend_q    <= n_pend_q;
            r_pend_qi   <= n_pend_qi;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hnext <= n_hnext;
    end

endmodule

FILE: rtl/multi_queue_shared_buffer_core.sv
// A result word is registered and appears in the cycle after its input word is taken.
// Throughput: one word per cycle; the input stalls only in reset or while a result waits.
// Free-list and head links are prefetched from the link RAM, one read a cycle.
// Reset (synchronous, active low) empties all queues and the result register and holds
// s_tready low; unused slots are tracked by a fill count, so no clearing pass is needed.
module multi_queue_shared_buffer_core
    import mqsb_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int QUEUES     = QUEUES_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // queue_id [2:0], value [34:3], zero [39:35]
    input  logic [0:0]  s_tuser,   // mode [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // status [1:0], data [33:2], zero [39:34]
);

    localparam int LW = $clog2(SLOTS + 1);
    localparam int IW = $clog2(SLOTS);

    logic                  accept;
    t_op_res               res;
    logic                  link_we, link_re, data_we, data_re;
    logic [IW-1:0]         link_waddr, link_raddr, data_waddr, data_raddr;
    logic [LW-1:0]         link_wdata, link_rdata;
    logic [63:0]           value_ext, rd_ext;
    logic [DATA_WIDTH-1:0] data_wdata, data_rdata;

    logic    r_out_valid;
    t_status r_status;
    logic    r_pop_ok;

    // hold the input off while reset is asserted
    assign s_tready = i_rst_n && (!r_out_valid || m_tready);
    assign accept   = s_tvalid && s_tready;

    mqsb_ctrl #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (accept),
        .i_mode       (s_tuser[0]),
        .i_queue_id   (s_tdata[QID_W-1:0]),
        .o_res        (res),
        .o_link_we    (link_we),
        .o_link_waddr (link_waddr),
        .o_link_wdata (link_wdata),
        .o_link_re    (link_re),
        .o_link_raddr (link_raddr),
        .i_link_rdata (link_rdata),
        .o_data_we    (data_we),
        .o_data_waddr (data_waddr),
        .o_data_re    (data_re),
        .o_data_raddr (data_raddr)
    );

    mqsb_ram #(
        .WIDTH (LW),
        .DEPTH (SLOTS)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    assign value_ext  = {32'b0, s_tdata[QID_W +: VALUE_W]};
    assign data_wdata = value_ext[DATA_WIDTH-1:0];

    mqsb_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (SLOTS)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_re    (data_re),
        .i_raddr (data_raddr),
        .o_rdata (data_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status <= res.status;
            r_pop_ok <= res.pop_ok;
        end
    end

    // the data RAM holds its read word while the result waits
    assign rd_ext   = 64'(data_rdata);
    assign m_tvalid = r_out_valid;
    assign m_tdata  = {6'b0, (r_pop_ok ? rd_ext[VALUE_W-1:0] : {VALUE_W{1'b0}}), r_status};

endmodule

FILE: rtl/mqsb_check.sv
module mqsb_check
    import mqsb_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic [0:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    a_reset_clears: assert property (@(posedge i_clk) !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted word gave no result");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

    a_fail_zero_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[1:0] != ST_OK)) |-> (m_tdata[33:2] == 32'd0))
        else $error("failed operation returned nonzero data");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind multi_queue_shared_buffer_core mqsb_check u_check (.*);
